@@ hw/rtl/dirty_rect_merge_table_top_defines.svh @@
// Assertion macros used by the dirty rectangle table RTL.
`ifndef DIRTY_RECT_MERGE_TABLE_TOP_DEFINES_SVH
`define DIRTY_RECT_MERGE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/drm_pkg.sv @@
// Package with the types and constants of the dirty rectangle table.
`default_nettype none

package drm_pkg;

	localparam int MaxRegions = 16;
	localparam int IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
	localparam int CntW = $clog2(MaxRegions + 1);

	localparam int PosW = 12;
	localparam int DimW = 13;
	localparam int EndW = DimW + 1;
	localparam int StatusW = 3;

	localparam logic [DimW-1:0] DimMax = {DimW{1'b1}};

	localparam logic [StatusW-1:0] StMerged = 3'd0;
	localparam logic [StatusW-1:0] StAppended = 3'd1;
	localparam logic [StatusW-1:0] StDropped = 3'd2;
	localparam logic [StatusW-1:0] StFlushed = 3'd3;
	localparam logic [StatusW-1:0] StNothing = 3'd4;

	typedef struct packed {
		logic [PosW-1:0] x;
		logic [PosW-1:0] y;
		logic [DimW-1:0] w;
		logic [DimW-1:0] h;
	} region_t;

endpackage

`default_nettype wire

@@ hw/rtl/dirty_rect_merge_table_top.sv @@
// Damage tracker: a small table of dirty rectangles with merge, append and flush.
`default_nettype none

// A mark item (kind 0) brings a rectangle; the block scans its stored
// entries in order, one entry per cycle, and the first entry that overlaps
// the rectangle strictly is replaced by the bounding box of both (width and
// height saturate at 8191). With no overlap the rectangle is appended, or,
// when all 16 entries are in use, dropped with status 2 and echoed back.
// Every mark gives exactly one result with last set. A flush item (kind 1)
// gives every stored rectangle in order with status 3, last on the final one,
// and then empties the table; an empty table gives one all-zero result with
// status 4. Timing: the block takes one item at a time and in_ready is low
// while it works. A mark is accepted, then the overlap comparator scans
// the entries; then the block appends or drops, or merges in the states
// S_MRG_X, S_MRG_Y and S_MRG_WR, since a single span unit (add, min/max,
// subtract, saturate) forms the x span and the y span in turn before the
// write back. A flush streams one result per cycle from the table's single
// read port while out_ready is high. The result register lets the next item
// be accepted while a finished result is still waiting to be taken.
module dirty_rect_merge_table_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         kind,
	input  wire logic [drm_pkg::PosW-1:0]     rect_x,
	input  wire logic [drm_pkg::PosW-1:0]     rect_y,
	input  wire logic [drm_pkg::DimW-1:0]     rect_w,
	input  wire logic [drm_pkg::DimW-1:0]     rect_h,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [drm_pkg::PosW-1:0]          out_x,
	output logic [drm_pkg::PosW-1:0]          out_y,
	output logic [drm_pkg::DimW-1:0]          out_w,
	output logic [drm_pkg::DimW-1:0]          out_h,
	output logic [drm_pkg::StatusW-1:0]       status,
	output logic                              last
);
	import drm_pkg::*;

	`include "dirty_rect_merge_table_top_defines.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_ADD,
		S_MRG_X,
		S_MRG_Y,
		S_MRG_WR,
		S_FLUSH,
		S_NONE
	} state_t;

	typedef struct packed {
		logic [PosW-1:0] lo;
		logic [DimW-1:0] len;
	} span_t;

	state_t state_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] idx_q;
	logic out_valid_q;
	logic [PosW-1:0] out_x_q;
	logic [PosW-1:0] out_y_q;
	logic [DimW-1:0] out_w_q;
	logic [DimW-1:0] out_h_q;
	logic [StatusW-1:0] status_q;
	logic last_q;

	// Table storage with one write port and one registered read port.
	region_t mem_q [2**IdxW];
	region_t rd_data_q;
	logic [IdxW-1:0] rd_addr;
	logic wr_en;
	logic [IdxW-1:0] wr_addr;
	region_t wr_data;

	// Item and merge working registers.
	region_t rect_q;
	region_t ent_q;
	logic [PosW-1:0] mx_q;
	logic [DimW-1:0] mw_q;

	logic slot_free;
	logic emit_go;
	logic accept;
	logic hit;
	logic scan_last;
	logic full;
	logic [CntW-1:0] idx_ext;
	logic [IdxW-1:0] idx_inc;
	logic [PosW-1:0] res_x;
	logic [PosW-1:0] res_y;
	logic [DimW-1:0] res_w;
	logic [DimW-1:0] res_h;
	logic [StatusW-1:0] res_status;
	logic res_last;

	// Shared span unit operands and result.
	logic [PosW-1:0] sp_a0;
	logic [DimW-1:0] sp_aw;
	logic [PosW-1:0] sp_b0;
	logic [DimW-1:0] sp_bw;
	logic [EndW-1:0] sp_a1;
	logic [EndW-1:0] sp_b1;
	logic [PosW-1:0] sp_lo;
	logic [EndW-1:0] sp_hi;
	logic [EndW-1:0] sp_diff;
	span_t sp_res;

	// Overlap test of the stored entry that was just read against the mark.
	logic [EndW-1:0] e_x1;
	logic [EndW-1:0] e_y1;
	logic [EndW-1:0] r_x1;
	logic [EndW-1:0] r_y1;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full = (count_q == CntW'(MaxRegions));
	assign idx_ext = CntW'(idx_q);
	assign idx_inc = IdxW'(idx_ext + CntW'(1));
	assign scan_last = ((idx_ext + CntW'(1)) == count_q);

	assign e_x1 = EndW'(rd_data_q.x) + EndW'(rd_data_q.w);
	assign e_y1 = EndW'(rd_data_q.y) + EndW'(rd_data_q.h);
	assign r_x1 = EndW'(rect_q.x) + EndW'(rect_q.w);
	assign r_y1 = EndW'(rect_q.y) + EndW'(rect_q.h);
	assign hit = (EndW'(rd_data_q.x) < r_x1) && (EndW'(rect_q.x) < e_x1) &&
		(EndW'(rd_data_q.y) < r_y1) && (EndW'(rect_q.y) < e_y1);

	// The span unit serves the x axis first, then the y axis.
	always_comb begin
		if (state_q == S_MRG_Y) begin
			sp_a0 = ent_q.y;
			sp_aw = ent_q.h;
			sp_b0 = rect_q.y;
			sp_bw = rect_q.h;
		end else begin
			sp_a0 = ent_q.x;
			sp_aw = ent_q.w;
			sp_b0 = rect_q.x;
			sp_bw = rect_q.w;
		end
		sp_a1 = EndW'(sp_a0) + EndW'(sp_aw);
		sp_b1 = EndW'(sp_b0) + EndW'(sp_bw);
		sp_lo = (sp_a0 < sp_b0) ? sp_a0 : sp_b0;
		sp_hi = (sp_a1 > sp_b1) ? sp_a1 : sp_b1;
		sp_diff = sp_hi - EndW'(sp_lo);
		sp_res.lo = sp_lo;
		sp_res.len = (sp_diff > EndW'(DimMax)) ? DimMax : sp_diff[DimW-1:0];
	end

	// Result selection and the table's port controls.
	always_comb begin
		emit_go = 1'b0;
		res_x = rect_q.x;
		res_y = rect_q.y;
		res_w = rect_q.w;
		res_h = rect_q.h;
		res_status = StAppended;
		res_last = 1'b1;
		rd_addr = idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rect_q;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = '0;
			end
			S_CMP: begin
				rd_addr = idx_inc;
			end
			S_ADD: begin
				emit_go = slot_free;
				res_status = full ? StDropped : StAppended;
				wr_en = slot_free && !full;
				wr_addr = count_q[IdxW-1:0];
			end
			S_MRG_X, S_MRG_Y: begin
			end
			S_MRG_WR: begin
				// The y span was parked in the entry register by the previous step.
				emit_go = slot_free;
				res_x = mx_q;
				res_y = ent_q.y;
				res_w = mw_q;
				res_h = ent_q.h;
				res_status = StMerged;
				wr_en = slot_free;
				wr_data = '{x: mx_q, y: ent_q.y, w: mw_q, h: ent_q.h};
			end
			S_FLUSH: begin
				emit_go = slot_free;
				res_x = rd_data_q.x;
				res_y = rd_data_q.y;
				res_w = rd_data_q.w;
				res_h = rd_data_q.h;
				res_status = StFlushed;
				res_last = scan_last;
				rd_addr = slot_free ? idx_inc : idx_q;
			end
			S_NONE: begin
				emit_go = slot_free;
				res_x = '0;
				res_y = '0;
				res_w = '0;
				res_h = '0;
				res_status = StNothing;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, table count and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_w_q <= '0;
			out_h_q <= '0;
			status_q <= StNothing;
			last_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				out_x_q <= res_x;
				out_y_q <= res_y;
				out_w_q <= res_w;
				out_h_q <= res_h;
				status_q <= res_status;
				last_q <= res_last;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (kind) begin
							state_q <= (count_q == '0) ? S_NONE : S_FLUSH;
						end else begin
							state_q <= (count_q == '0) ? S_ADD : S_CMP;
						end
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_MRG_X;
					end else if (scan_last) begin
						state_q <= S_ADD;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_ADD: begin
					if (emit_go) begin
						if (!full) begin
							count_q <= count_q + CntW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_MRG_X: begin
					state_q <= S_MRG_Y;
				end
				S_MRG_Y: begin
					state_q <= S_MRG_WR;
				end
				S_MRG_WR: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (emit_go) begin
						if (scan_last) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				S_NONE: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers and the table memory.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rect_q <= '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};
		end
		if (state_q == S_CMP && hit) begin
			ent_q <= rd_data_q;
		end
		if (state_q == S_MRG_X) begin
			mx_q <= sp_res.lo;
			mw_q <= sp_res.len;
		end
		if (state_q == S_MRG_Y) begin
			ent_q.y <= sp_res.lo;
			ent_q.h <= sp_res.len;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_w = out_w_q;
	assign out_h = out_h_q;
	assign status = status_q;
	assign last = last_q;

	// The table never holds more entries than it has room for.
	`DRM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(MaxRegions),
		"region count above table depth")
	// Scanning and flushing only touch entries that are in use.
	`DRM_ASSERT_NOW(a_idx_in_use, state_q == S_CMP || state_q == S_FLUSH,
		idx_ext < count_q, "table index beyond region count")
	// Back in idle, a waiting result is always the final one of its item.
	`DRM_ASSERT_NOW(a_idle_last, state_q == S_IDLE && out_valid_q, last_q,
		"idle with a result that is not the last one")
	// The final flushed result leaves the table empty.
	`DRM_ASSERT_NEXT(a_flush_clears, state_q == S_FLUSH && emit_go && scan_last,
		count_q == '0, "table not empty after flush")
	// An append grows the table by exactly one entry.
	`DRM_ASSERT_NEXT(a_append_grows, state_q == S_ADD && emit_go && !full,
		count_q == $past(count_q) + CntW'(1), "append did not grow the table")

endmodule

`default_nettype wire
